>>> rtl/core/blps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button LED pattern sequencer.
// No dependencies.
package blps_pkg;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_WAIT    = 3'd1,
        PH_INC     = 3'd2,
        PH_DEC     = 3'd3,
        PH_BOTH    = 3'd4,
        PH_RELEASE = 3'd5
    } button_phase_t;

    localparam int NUM_TASKS   = 4;
    localparam int PERIOD_W    = 16;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // task / register indexes
    localparam logic [1:0] TASK_BUTTON  = 2'd0;
    localparam logic [1:0] TASK_BLINK   = 2'd1;
    localparam logic [1:0] TASK_CHECKER = 2'd2;
    localparam logic [1:0] TASK_BAR     = 2'd3;

    localparam logic [PERIOD_W-1:0] BUTTON_PERIOD_RST  = 16'd50;
    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST   = 16'd800;
    localparam logic [PERIOD_W-1:0] CHECKER_PERIOD_RST = 16'd500;
    localparam logic [PERIOD_W-1:0] BAR_PERIOD_RST     = 16'd100;

    // pattern selection codes
    localparam logic [1:0] SEL_BLINK   = 2'd1;
    localparam logic [1:0] SEL_CHECKER = 2'd2;
    localparam logic [1:0] SEL_BAR     = 2'd3;

    localparam logic [7:0] LED_ALL_ON  = 8'hFF;
    localparam logic [7:0] LED_ALL_OFF = 8'h00;
    localparam logic [7:0] LED_CHK_A   = 8'hAA;
    localparam logic [7:0] LED_CHK_B   = 8'h55;

    function automatic logic [7:0] bar_pattern(input logic [2:0] step);
        logic [7:0] pat;
        case (step)
            3'd0:    pat = 8'h00;
            3'd1:    pat = 8'h81;
            3'd2:    pat = 8'hC3;
            3'd3:    pat = 8'hE7;
            3'd4:    pat = 8'hFF;
            3'd5:    pat = 8'hE7;
            3'd6:    pat = 8'hC3;
            3'd7:    pat = 8'h81;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/core/button_led_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the button LED pattern sequencer: tick scheduler, button
// machine, pattern generators, APB period registers. Uses blps_pkg.

// One beat on the item channel is one millisecond tick carrying the two
// button levels; one beat on the result channel returns the LED byte for
// that tick (zero while power is off). A tick is accepted every cycle while
// the result register is empty or being drained, so the sustained rate is
// one tick per clock, and the result is registered: the whole state update
// (four period counters, the button machine, then the blink, checker and
// bar steps) is one combinational pass into the state and result registers.
// Periods sit at APB byte addresses 0x0, 0x4, 0x8, 0xC (button, blink,
// checker, bar); writing one leaves the elapsed counts untouched, so a period
// set below the current count runs again only after the 16-bit count wraps.
module button_led_pattern_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic                           dec_button,
    input  logic                           inc_button,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [7:0]                     led_byte,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [blps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [blps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [blps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import blps_pkg::*;

    logic [PERIOD_W-1:0] period_reg  [NUM_TASKS];
    logic [PERIOD_W-1:0] elapsed_reg [NUM_TASKS];
    logic [PERIOD_W-1:0] elapsed_next[NUM_TASKS];
    logic [NUM_TASKS-1:0] started_reg, started_next;
    logic [NUM_TASKS-1:0] hit;

    button_phase_t phase_reg, phase_next;
    logic [1:0] sel_reg, sel_next;
    logic       power_reg, power_next;
    logic       latched_reg, latched_next;
    logic [7:0] pat_reg, pat_next;
    logic       blink_reg, blink_next;
    logic       chk_reg, chk_next;
    logic [2:0] bar_reg, bar_next;

    logic       result_valid_reg;
    logic [7:0] led_byte_reg, led_byte_next;
    logic       item_fire;
    logic       cfg_write;
    logic [1:0] cfg_index;

    assign item_ready   = !result_valid_reg || result_ready;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign led_byte     = led_byte_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign prdata    = {{(CFG_DATA_W-PERIOD_W){1'b0}}, period_reg[cfg_index]};

    // scheduler: run when count equals period, then clear and count up
    always_comb
    begin
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            hit[k]          = (elapsed_reg[k] == period_reg[k]);
            elapsed_next[k] = (hit[k] ? '0 : elapsed_reg[k]) + PERIOD_W'(1);
        end
        started_next = started_reg | hit;
    end

    // button machine, then the three pattern tasks in order
    always_comb
    begin
        logic a;
        logic b;
        a            = dec_button;
        b            = inc_button;
        phase_next   = phase_reg;
        sel_next     = sel_reg;
        power_next   = power_reg;
        latched_next = latched_reg;
        pat_next     = pat_reg;
        blink_next   = blink_reg;
        chk_next     = chk_reg;
        bar_next     = bar_reg;

        if (hit[TASK_BUTTON])
        begin
            if (!started_reg[TASK_BUTTON])
            begin
                phase_next = PH_WAIT;
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (a && b)
                            phase_next = PH_BOTH;
                        else if (a)
                            phase_next = PH_DEC;
                        else if (b)
                            phase_next = PH_INC;
                    end
                    PH_INC:
                    begin
                        sel_next   = (sel_reg == SEL_BAR) ? SEL_BLINK : sel_reg + 2'd1;
                        phase_next = PH_RELEASE;
                    end
                    PH_DEC:
                    begin
                        sel_next   = (sel_reg <= SEL_BLINK) ? SEL_BAR : sel_reg - 2'd1;
                        phase_next = PH_RELEASE;
                    end
                    PH_BOTH:
                    begin
                        if (!latched_reg)
                        begin
                            power_next   = !power_reg;
                            sel_next     = SEL_BLINK;
                            latched_next = 1'b1;
                        end
                        phase_next = PH_RELEASE;
                    end
                    PH_RELEASE:
                    begin
                        if (!a && !b)
                        begin
                            phase_next   = PH_WAIT;
                            latched_next = 1'b0;
                        end
                        else if (a && b)
                        begin
                            phase_next = PH_BOTH;
                        end
                    end
                    default: phase_next = PH_WAIT;
                endcase
            end
        end

        // pattern tasks see selection and power as left by the button task
        if (hit[TASK_BLINK] && started_reg[TASK_BLINK])
        begin
            if (sel_next != SEL_BLINK)
                blink_next = 1'b0;
            else if (power_next)
            begin
                pat_next   = blink_reg ? LED_ALL_OFF : LED_ALL_ON;
                blink_next = !blink_reg;
            end
        end

        if (hit[TASK_CHECKER] && started_reg[TASK_CHECKER])
        begin
            if (sel_next != SEL_CHECKER)
                chk_next = 1'b0;
            else if (power_next)
            begin
                pat_next = chk_reg ? LED_CHK_B : LED_CHK_A;
                chk_next = !chk_reg;
            end
        end

        if (hit[TASK_BAR] && started_reg[TASK_BAR])
        begin
            if (sel_next != SEL_BAR)
                bar_next = 3'd0;
            else if (power_next)
            begin
                pat_next = bar_pattern(bar_reg);
                bar_next = bar_reg + 3'd1;
            end
        end

        led_byte_next = power_next ? pat_next : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg[TASK_BUTTON]  <= BUTTON_PERIOD_RST;
            period_reg[TASK_BLINK]   <= BLINK_PERIOD_RST;
            period_reg[TASK_CHECKER] <= CHECKER_PERIOD_RST;
            period_reg[TASK_BAR]     <= BAR_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            period_reg[cfg_index] <= pwdata[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg[TASK_BUTTON]  <= BUTTON_PERIOD_RST;
            elapsed_reg[TASK_BLINK]   <= BLINK_PERIOD_RST;
            elapsed_reg[TASK_CHECKER] <= CHECKER_PERIOD_RST;
            elapsed_reg[TASK_BAR]     <= BAR_PERIOD_RST;
            started_reg <= '0;
            phase_reg   <= PH_START;
            sel_reg     <= SEL_BLINK;
            power_reg   <= 1'b0;
            latched_reg <= 1'b0;
            pat_reg     <= 8'h00;
            blink_reg   <= 1'b0;
            chk_reg     <= 1'b0;
            bar_reg     <= 3'd0;
        end
        else if (item_fire)
        begin
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                elapsed_reg[k] <= elapsed_next[k];
            end
            started_reg <= started_next;
            phase_reg   <= phase_next;
            sel_reg     <= sel_next;
            power_reg   <= power_next;
            latched_reg <= latched_next;
            pat_reg     <= pat_next;
            blink_reg   <= blink_next;
            chk_reg     <= chk_next;
            bar_reg     <= bar_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            led_byte_reg <= led_byte_next;
        end
    end

endmodule

>>> tb/tb_button_led_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for button_led_pattern_sequencer_unit: scripted and random
// button ticks, APB period setup, LED bytes checked against a cycle model.
// Depends on blps_pkg and the RTL top level only.
module tb_button_led_pattern_sequencer_unit;

    import blps_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 225;
    localparam int HUGE_PHASE     = 2;     // pattern periods at their maximum
    localparam int WRAP_PHASE     = 6;     // pattern periods may drop below the count
    localparam int BURST_PHASE_A  = 1;
    localparam int BURST_PHASE_B  = 5;
    localparam int STALL_PHASE_A  = 0;
    localparam int STALL_PHASE_B  = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [7:0] BAR_LEVELS [8] = '{
        8'h00, 8'h81, 8'hC3, 8'hE7, 8'hFF, 8'hE7, 8'hC3, 8'h81
    };

    typedef struct packed {
        logic [1:0] btns;   // {dec, inc}
        logic       lit;    // led value typed in below, else from the model
        logic [7:0] led;
    } tick_row_t;

    localparam int DIRECTED_ROWS = 22;
    // row 0 runs on reset periods; all periods are 1 from row 1 on
    localparam tick_row_t PRESS_SCRIPT [DIRECTED_ROWS] = '{
        '{2'b11, 1'b1, 8'h00},  // first tick only starts the tasks, power off
        '{2'b11, 1'b1, 8'h00},  // both seen while waiting, power still off
        '{2'b11, 1'b0, 8'h00},  // power toggles on, blink
        '{2'b11, 1'b0, 8'h00},
        '{2'b11, 1'b0, 8'h00},  // still the same press, no second toggle
        '{2'b00, 1'b0, 8'h00},
        '{2'b01, 1'b0, 8'h00},
        '{2'b01, 1'b0, 8'h00},  // checker
        '{2'b00, 1'b0, 8'h00},
        '{2'b01, 1'b0, 8'h00},
        '{2'b00, 1'b0, 8'h00},  // bar
        '{2'b00, 1'b0, 8'h00},
        '{2'b01, 1'b0, 8'h00},
        '{2'b01, 1'b0, 8'h00},  // select wraps up to blink
        '{2'b00, 1'b0, 8'h00},
        '{2'b10, 1'b0, 8'h00},
        '{2'b10, 1'b0, 8'h00},  // select wraps down to bar
        '{2'b11, 1'b0, 8'h00},
        '{2'b11, 1'b0, 8'h00},  // power off
        '{2'b00, 1'b0, 8'h00},
        '{2'b10, 1'b0, 8'h00},
        '{2'b00, 1'b0, 8'h00}   // select moves while off, byte stays zero
    };

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    logic                  dec_button;
    logic                  inc_button;
    logic                  result_valid;
    logic                  result_ready;
    logic [7:0]            led_byte;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    logic [PERIOD_W-1:0] period_cfg  [NUM_TASKS];
    logic [PERIOD_W-1:0] elapsed_cnt [NUM_TASKS];
    logic                task_live   [NUM_TASKS];
    button_phase_t       btn_phase;
    logic [1:0]          pat_sel;
    logic                power;
    logic                toggle_held;
    logic [7:0]          led_pat;
    logic                blink_on;
    logic                chk_alt;
    logic [2:0]          bar_idx;

    logic [7:0] pending_leds [$];
    int         fail_count    = 0;
    bit         no_gaps       = 1'b0;
    bit         stall_request = 1'b0;

    button_led_pattern_sequencer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .dec_button   (dec_button),
        .inc_button   (inc_button),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .led_byte     (led_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one tick of the sequencer: scheduler, button machine, pattern steps
    task automatic advance_tick(input logic dn, input logic up, output logic [7:0] led);
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            if (elapsed_cnt[k] == period_cfg[k])
            begin
                if (!task_live[k])
                begin
                    task_live[k] = 1'b1;
                    if (k == TASK_BUTTON)
                        btn_phase = PH_WAIT;
                end
                else
                begin
                    case (k)
                        TASK_BUTTON:
                        begin
                            case (btn_phase)
                                PH_WAIT:
                                begin
                                    // both-button check wins over a single press
                                    if (dn && up)
                                        btn_phase = PH_BOTH;
                                    else if (dn)
                                        btn_phase = PH_DEC;
                                    else if (up)
                                        btn_phase = PH_INC;
                                end
                                PH_INC:
                                begin
                                    pat_sel = (pat_sel == SEL_BAR) ? SEL_BLINK : pat_sel + 2'd1;
                                    btn_phase = PH_RELEASE;
                                end
                                PH_DEC:
                                begin
                                    pat_sel = (pat_sel == SEL_BLINK) ? SEL_BAR : pat_sel - 2'd1;
                                    btn_phase = PH_RELEASE;
                                end
                                PH_BOTH:
                                begin
                                    if (!toggle_held)
                                    begin
                                        power = ~power;
                                        pat_sel = SEL_BLINK;
                                        toggle_held = 1'b1;
                                    end
                                    btn_phase = PH_RELEASE;
                                end
                                PH_RELEASE:
                                begin
                                    if (!dn && !up)
                                    begin
                                        btn_phase = PH_WAIT;
                                        toggle_held = 1'b0;
                                    end
                                    else if (dn && up)
                                    begin
                                        btn_phase = PH_BOTH;
                                    end
                                end
                                default:
                                    btn_phase = PH_WAIT;
                            endcase
                        end
                        TASK_BLINK:
                        begin
                            if (pat_sel != SEL_BLINK)
                            begin
                                blink_on = 1'b0;
                            end
                            else if (power)
                            begin
                                led_pat = blink_on ? LED_ALL_OFF : LED_ALL_ON;
                                blink_on = ~blink_on;
                            end
                        end
                        TASK_CHECKER:
                        begin
                            if (pat_sel != SEL_CHECKER)
                            begin
                                chk_alt = 1'b0;
                            end
                            else if (power)
                            begin
                                led_pat = chk_alt ? LED_CHK_B : LED_CHK_A;
                                chk_alt = ~chk_alt;
                            end
                        end
                        default:
                        begin
                            if (pat_sel != SEL_BAR)
                            begin
                                bar_idx = 3'd0;
                            end
                            else if (power)
                            begin
                                led_pat = BAR_LEVELS[bar_idx];
                                bar_idx = bar_idx + 3'd1;
                            end
                        end
                    endcase
                end
                elapsed_cnt[k] = '0;
            end
            elapsed_cnt[k] = elapsed_cnt[k] + 1'b1;
        end
        led = power ? led_pat : LED_ALL_OFF;
    endtask

    // APB write, then read back the same register, then return the bus to idle
    task automatic write_period(input logic [1:0] idx, input logic [PERIOD_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        period_cfg[idx] = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd !== {16'h0000, value})
            note_failure($sformatf("period %0d read %08h, wrote %04h", idx, rd, value));
    endtask

    // offer one tick beat, hold it until taken, then log the predicted led byte
    task automatic send_tick(input logic [1:0] btns, input logic lit, input logic [7:0] lit_led);
        logic [7:0] led;
        int         gap;
        item_valid <= 1'b1;
        dec_button <= btns[1];
        inc_button <= btns[0];
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        advance_tick(btns[1], btns[0], led);
        pending_leds.push_back(lit ? lit_led : led);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_leds.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side
    initial
    begin
        logic [7:0] want;
        int         idle_left;
        idle_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_leds.size() == 0)
                begin
                    note_failure($sformatf("led beat %02h with nothing pending", led_byte));
                end
                else
                begin
                    want = pending_leds.pop_front();
                    if (led_byte !== want)
                        note_failure($sformatf("led_byte expected %02h got %02h", want, led_byte));
                end
                idle_left = pick_gap();
            end
            // long hold-off so the result register fills and the tick side backs up
            if (stall_request)
            begin
                stall_request = 1'b0;
                idle_left = $urandom_range(200, 320);
            end
            if (idle_left > 0)
            begin
                idle_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int         want;
        int         sent;
        int         hold;
        int         rest;
        int         unit;
        int         kind;
        int         lead;
        logic [1:0] lvl;
        logic [1:0] lead_lvl;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        dec_button <= 1'b0;
        inc_button <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        period_cfg[TASK_BUTTON]  = BUTTON_PERIOD_RST;
        period_cfg[TASK_BLINK]   = BLINK_PERIOD_RST;
        period_cfg[TASK_CHECKER] = CHECKER_PERIOD_RST;
        period_cfg[TASK_BAR]     = BAR_PERIOD_RST;
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            elapsed_cnt[k] = period_cfg[k];
            task_live[k]   = 1'b0;
        end
        btn_phase   = PH_START;
        pat_sel     = SEL_BLINK;
        power       = 1'b0;
        toggle_held = 1'b0;
        led_pat     = LED_ALL_OFF;
        blink_on    = 1'b0;
        chk_alt     = 1'b0;
        bar_idx     = 3'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (r == 1)
            begin
                settle();
                for (int k = 0; k < NUM_TASKS; k++)
                    write_period(2'(k), 16'd1);
            end
            send_tick(PRESS_SCRIPT[r].btns, PRESS_SCRIPT[r].lit, PRESS_SCRIPT[r].led);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                if (p == HUGE_PHASE && k != TASK_BUTTON)
                    want = 65535;
                else if ($urandom_range(0, 3) == 0)
                    want = $urandom_range(7, 40);
                else
                    want = $urandom_range(1, 6);
                // below the running count the task sleeps until the count wraps
                if ((p != WRAP_PHASE || k == TASK_BUTTON) && want < elapsed_cnt[k])
                    want = elapsed_cnt[k];
                write_period(2'(k), 16'(want));
            end
            no_gaps = (p == BURST_PHASE_A || p == BURST_PHASE_B);
            if (p == STALL_PHASE_A || p == STALL_PHASE_B)
                stall_request = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // press lengths scale with the button period so presses register
                unit = (period_cfg[TASK_BUTTON] > 20) ? 20 : int'(period_cfg[TASK_BUTTON]);
                hold = unit * $urandom_range(1, 3) + $urandom_range(0, 2);
                rest = unit * $urandom_range(1, 2) + $urandom_range(0, 1);
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2: lvl = 2'b01;
                    3, 4, 5: lvl = 2'b10;
                    9:       lvl = 2'b00;
                    default: lvl = 2'b11;
                endcase
                // staggered two-button press: one button goes down first
                if (kind == 7)
                begin
                    lead = $urandom_range(1, unit);
                    lead_lvl = ($urandom_range(0, 1) == 1) ? 2'b10 : 2'b01;
                    for (int i = 0; i < lead; i++)
                    begin
                        send_tick(lead_lvl, 1'b0, 8'h00);
                        sent++;
                    end
                end
                for (int i = 0; i < hold; i++)
                begin
                    send_tick((kind == 8) ? 2'($urandom) : lvl, 1'b0, 8'h00);
                    sent++;
                end
                // release, with an occasional bounce
                for (int i = 0; i < rest; i++)
                begin
                    send_tick(($urandom_range(0, 15) == 0) ? 2'($urandom) : 2'b00, 1'b0, 8'h00);
                    sent++;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/blps_pkg.sv
rtl/core/button_led_pattern_sequencer_unit.sv
tb/tb_button_led_pattern_sequencer_unit.sv
